### design/mlra_pkg.sv
// ----------------------------------------------------------------------------
// mlra_pkg
// Shared types and constants of the multi-lane running average block.
// ----------------------------------------------------------------------------
package mlra_pkg;

  localparam int LANES_DEF  = 15;
  localparam int LANE_W     = 4;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int PROD_W     = 64;
  localparam int DEN_W      = COUNT_W + 1;
  localparam int QUOT_W     = PROD_W - DATA_W;
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SKIP  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [LANE_W-1:0]        lane;
    logic signed [DATA_W-1:0] sample;
    logic                     eor;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/mlra_front.sv
// ----------------------------------------------------------------------------
// mlra_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mlra_front #(
  parameter int LANES = mlra_pkg::LANES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op_i,
  input  logic [mlra_pkg::LANE_W-1:0]          lane_i,
  input  logic signed [mlra_pkg::DATA_W-1:0]   sample_i,
  input  logic                                 end_of_record_i,
  output mlra_pkg::cmd_t                       cmd_o,
  output logic                                 cmd_valid_o,
  input  logic                                 cmd_pop_i
);
  import mlra_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             cmd_in;
  cmd_t             q_mem [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  always_comb begin
    cmd_in.lane   = lane_i;
    cmd_in.sample = sample_i;
    cmd_in.eor    = end_of_record_i;
    if (op_i == OP_CLEAR) begin
      cmd_in.kind = CMD_CLEAR;
    end else if (32'(lane_i) < 32'(LANES)) begin
      cmd_in.kind = CMD_ADD;
    end else begin
      cmd_in.kind = CMD_SKIP;
    end
  end

  assign full        = (cnt_q == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### design/mlra_div.sv
// ----------------------------------------------------------------------------
// mlra_div
// Radix-2 restoring divider, one quotient bit per cycle. The dividend must
// be below divisor * 2^QUOT_W so that the quotient fits QUOT_W bits.
// ----------------------------------------------------------------------------
module mlra_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlra_pkg::div_req_t req_i,
  output mlra_pkg::div_rsp_t rsp_o
);
  import mlra_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [QUOT_W-1:0] acc_q, acc_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, acc_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = {1'b0, req_i.dividend[PROD_W-1:QUOT_W]};
      acc_d  = req_i.dividend[QUOT_W-1:0];
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_d  = {acc_q[QUOT_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = acc_q;

endmodule

### design/mlra_back.sv
// ----------------------------------------------------------------------------
// mlra_back
// Carries out queued commands: lane average store, record count, fold
// sequencer with multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
module mlra_back #(
  parameter int LANES = mlra_pkg::LANES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mlra_pkg::cmd_t                      cmd_i,
  input  logic                                cmd_valid_i,
  output logic                                cmd_pop_o,
  output mlra_pkg::div_req_t                  div_req_o,
  input  mlra_pkg::div_rsp_t                  div_rsp_i,
  output logic                                out_valid_o,
  input  logic                                pop_i,
  output logic [mlra_pkg::LANE_W-1:0]         lane_out_o,
  output logic signed [mlra_pkg::DATA_W-1:0]  average_o,
  output logic [mlra_pkg::COUNT_W-1:0]        record_count_o
);
  import mlra_pkg::*;

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic [LANE_W-1:0]          lane_q;
  logic signed [DATA_W-1:0]   sample_q;
  logic                       eor_q;
  logic                       neg_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [DATA_W-1:0]          avg_mem [LANES];
  logic [LANES-1:0]           vld_q, vld_d;
  logic [DATA_W-1:0]          rd_avg_q;
  logic                       rd_vld_q;
  logic                       out_valid_q, out_valid_d;
  logic [LANE_W-1:0]          out_lane_q, out_lane_d;
  logic signed [DATA_W-1:0]   out_avg_q, out_avg_d;
  logic [COUNT_W-1:0]         out_count_q, out_count_d;
  logic                       out_load;
  logic                       pop_ok, slot_free;
  logic [IDX_W-1:0]           rd_idx, wr_idx;
  logic                       mem_we;
  logic [DATA_W-1:0]          mem_wdata;
  logic signed [DATA_W-1:0]   avg_rd;
  logic signed [DATA_W+COUNT_W:0] prod_full;
  logic signed [PROD_W-1:0]   num;
  logic [PROD_W-1:0]          mag;
  logic signed [DATA_W-1:0]   fold_res;
  logic [COUNT_W-1:0]         count_inc;

  assign pop_ok    = pop_i && out_valid_q;
  assign slot_free = !out_valid_q || pop_ok;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && slot_free;
  assign rd_idx    = IDX_W'(cmd_i.lane);
  assign wr_idx    = IDX_W'((state_q == S_DONE) ? lane_q : cmd_i.lane);

  assign avg_rd    = rd_vld_q ? $signed(rd_avg_q) : '0;
  assign prod_full = avg_rd * $signed({1'b0, count_q});
  assign num       = prod_q + PROD_W'(sample_q);
  assign mag       = num[PROD_W-1] ? (~num + 1'b1) : num;
  assign fold_res  = neg_q ? -$signed(div_rsp_i.quotient) : $signed(div_rsp_i.quotient);

  always_comb begin
    logic eor_sel;
    eor_sel   = (state_q == S_DONE) ? eor_q : cmd_i.eor;
    count_inc = (eor_sel && (count_q != '1)) ? count_q + 1'b1 : count_q;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    vld_d       = vld_q;
    mem_we      = 1'b0;
    mem_wdata   = cmd_i.sample;
    out_load    = 1'b0;
    out_lane_d  = cmd_i.lane;
    out_avg_d   = '0;
    out_count_d = count_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = mag;
    div_req_o.divisor  = {1'b0, count_q} + 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          unique case (cmd_i.kind)
            CMD_CLEAR: begin
              vld_d      = '0;
              count_d    = '0;
              out_load   = 1'b1;
              out_lane_d = '0;
              out_count_d = '0;
            end
            CMD_SKIP: begin
              out_load = 1'b1;
            end
            CMD_ADD: begin
              if (count_q == '0) begin
                mem_we         = 1'b1;
                vld_d[wr_idx]  = 1'b1;
                count_d        = count_inc;
                out_load       = 1'b1;
                out_avg_d      = cmd_i.sample;
                out_count_d    = count_inc;
              end else begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: state_d = S_MUL;
      S_MUL: begin
        div_req_o.start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          mem_we        = 1'b1;
          mem_wdata     = fold_res;
          vld_d[wr_idx] = 1'b1;
          count_d       = count_inc;
          out_load      = 1'b1;
          out_lane_d    = lane_q;
          out_avg_d     = fold_res;
          out_count_d   = count_inc;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (pop_ok ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      avg_mem[wr_idx] <= mem_wdata;
    end
    rd_avg_q <= avg_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_q[rd_idx];
    if (cmd_pop_o) begin
      lane_q   <= cmd_i.lane;
      sample_q <= cmd_i.sample;
      eor_q    <= cmd_i.eor;
    end
    if (state_q == S_READ) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    if (state_q == S_MUL) begin
      neg_q <= num[PROD_W-1];
    end
    if (out_load) begin
      out_lane_q  <= out_lane_d;
      out_avg_q   <= out_avg_d;
      out_count_q <= out_count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lane_out_o     = out_lane_q;
  assign average_o      = out_avg_q;
  assign record_count_o = out_count_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_count_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_pop_o && cmd_i.kind == CMD_CLEAR) |=> count_q >= $past(count_q))
    else $error("record count fell without a clear");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_avg_q)
      && $stable(out_count_q))
    else $error("waiting result word changed before pop");

endmodule

### design/multi_lane_running_average_core.sv
// ----------------------------------------------------------------------------
// multi_lane_running_average_core
// Cumulative average per lane with a shared record count.
//
//   channel  | handshake          | word
//   ---------+--------------------+-------------------------------------------
//   input    | push / full        | op_i, lane_i, sample_i, end_of_record_i
//   result   | pop / empty        | lane_out_o, average_o, record_count_o
//
// Clear, out-of-range lane and first-record words are finished in the idle state.
// A fold steps through store read, 33x32 multiply, 32 divider steps at one
// quotient bit each, and write-back.
// Reset clears count and lane valid bits at once; no sweep.
// A two-word queue sits between input and sequencer; a waiting result
// stalls only the sequencer.
// ----------------------------------------------------------------------------
module multi_lane_running_average_core #(
  parameter int LANES = mlra_pkg::LANES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                op_i,
  input  logic [mlra_pkg::LANE_W-1:0]         lane_i,
  input  logic signed [mlra_pkg::DATA_W-1:0]  sample_i,
  input  logic                                end_of_record_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [mlra_pkg::LANE_W-1:0]         lane_out_o,
  output logic signed [mlra_pkg::DATA_W-1:0]  average_o,
  output logic [mlra_pkg::COUNT_W-1:0]        record_count_o
);
  import mlra_pkg::*;

  cmd_t     cmd;
  logic     cmd_valid, cmd_pop, out_valid;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mlra_front #(.LANES(LANES)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .lane_i          (lane_i),
    .sample_i        (sample_i),
    .end_of_record_i (end_of_record_i),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop)
  );

  mlra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mlra_back #(.LANES(LANES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid),
    .pop_i          (pop),
    .lane_out_o     (lane_out_o),
    .average_o      (average_o),
    .record_count_o (record_count_o)
  );

  assign empty = !out_valid;

endmodule

### tb/multi_lane_running_average_core_test.sv
// ----------------------------------------------------------------------------
// multi_lane_running_average_core_test
// Drives add and clear words into the running average core and checks every
// result word against a predictor of the per-lane averages and the shared
// record count. A directed opening covers the signed extremes, truncation
// toward zero, out-of-range lanes and clears. Random records with random
// idling, a long receiver hold-off and a drain pause follow.
// ----------------------------------------------------------------------------
module multi_lane_running_average_core_test;
  import mlra_pkg::*;

  localparam int LANES     = LANES_DEF;
  localparam int N_RANDOM  = 1150;
  localparam int HOLD_CYC  = 400;
  localparam int TAIL_CYC  = 100;
  localparam int LIMIT_CYC = 300000;

  typedef struct packed {
    logic [LANE_W-1:0]        lane;
    logic signed [DATA_W-1:0] average;
    logic [COUNT_W-1:0]       count;
  } lane_update_t;

  class avg_scoreboard;
    bit signed [DATA_W-1:0] lane_avg [LANES];
    bit [COUNT_W-1:0]       records;
    lane_update_t           due_updates [$];
    int                     errors;
    int                     seen;

    function void note_word(op_e op, logic [LANE_W-1:0] lane, logic signed [DATA_W-1:0] value,
                            logic eor);
      lane_update_t upd;
      longint       num;
      longint       den;
      longint       rec64;
      if (op == OP_CLEAR) begin
        lane_avg = '{default: '0};
        records  = '0;
        upd      = '0;
      end else if (lane >= LANES) begin
        upd = '{lane: lane, average: '0, count: records};
      end else begin
        if (records == 0) begin
          lane_avg[lane] = value;
        end else begin
          rec64 = {32'd0, records};
          num   = longint'(lane_avg[lane]) * rec64 + longint'(value);
          den   = rec64 + 64'sd1;
          num   = num / den;
          lane_avg[lane] = num[DATA_W-1:0];
        end
        if (eor && records != '1) records = records + 1;
        upd = '{lane: lane, average: lane_avg[lane], count: records};
      end
      due_updates.push_back(upd);
    endfunction

    function void check_update(logic [LANE_W-1:0] lane, logic signed [DATA_W-1:0] avg,
                               logic [COUNT_W-1:0] count);
      lane_update_t upd;
      seen++;
      if (due_updates.size() == 0) begin
        $error("unexpected word: lane_out_o %0d average_o %0d record_count_o %0d",
               lane, avg, count);
        errors++;
        return;
      end
      upd = due_updates.pop_front();
      if (lane !== upd.lane) begin
        $error("lane_out_o: expected %0d, actual %0d", upd.lane, lane);
        errors++;
      end
      if (avg !== upd.average) begin
        $error("average_o: expected %0d, actual %0d", upd.average, avg);
        errors++;
      end
      if (count !== upd.count) begin
        $error("record_count_o: expected %0d, actual %0d", upd.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return due_updates.size();
    endfunction
  endclass

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     push            = 1'b0;
  logic                     full;
  logic                     op_i            = 1'b0;
  logic [LANE_W-1:0]        lane_i          = '0;
  logic signed [DATA_W-1:0] sample_i        = '0;
  logic                     end_of_record_i = 1'b0;
  logic                     empty;
  logic                     pop             = 1'b0;
  logic [LANE_W-1:0]        lane_out_o;
  logic signed [DATA_W-1:0] average_o;
  logic [COUNT_W-1:0]       record_count_o;

  avg_scoreboard sb = new();
  int            sent;

  multi_lane_running_average_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .lane_i          (lane_i),
    .sample_i        (sample_i),
    .end_of_record_i (end_of_record_i),
    .empty           (empty),
    .pop             (pop),
    .lane_out_o      (lane_out_o),
    .average_o       (average_o),
    .record_count_o  (record_count_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_word(op_e'(op_i), lane_i, sample_i, end_of_record_i);
    if (rst_ni && pop && !empty) sb.check_update(lane_out_o, average_o, record_count_o);
  end

  // Enter and leave just after a falling edge; push stays high on return.
  task automatic send_word(input op_e op, input logic [LANE_W-1:0] lane,
                           input logic signed [DATA_W-1:0] value, input logic eor,
                           input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 8) begin
        push = 1'b0;
        @(negedge clk_i);
      end
    end
    push            = 1'b1;
    op_i            = op;
    lane_i          = lane;
    sample_i        = value;
    end_of_record_i = eor;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain_updates();
    push = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin : result_sink
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.seen >= 150) begin
        held = 1'b1;
        pop  = 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end
      if (sb.seen >= 500 && sb.seen < 750) pop = 1'b1;
      else pop = ($urandom_range(99) >= 8);
    end
  end

  initial begin : stimulus
    int                       n_words;
    int                       roll;
    bit                       paused;
    logic signed [DATA_W-1:0] value;
    logic                     eor;
    sent   = 0;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(OP_ADD, 4'd0, 32'sh8000_0000, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd14, 32'sh7fff_ffff, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd0, 32'sh7fff_ffff, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd14, 32'sh8000_0000, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd15, 32'sh7fff_ffff, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd5, -32'sd7, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd5, 32'sd7, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd9, 32'sh5555_5555, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd10, 32'shaaaa_aaaa, 1'b1, 1'b0);
    send_word(OP_CLEAR, 4'd15, -32'sd1, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd15, 32'sd0, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd3, -32'sd1, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd3, 32'sd0, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd8, 32'sh8000_0000, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd8, 32'sh8000_0000, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd8, 32'sh7fff_ffff, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd12, 32'sh0000_0001, 1'b0, 1'b0);
    send_word(OP_CLEAR, 4'd0, 32'sd0, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd1, 32'sd0, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd7, 32'sh7fff_ffff, 1'b1, 1'b0);

    sent = 0;
    while (sent < N_RANDOM) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_word(OP_CLEAR, LANE_W'($urandom), $urandom, 1'($urandom), !(sent >= 600 && sent < 850));
      end else if (roll < 7) begin
        send_word(OP_ADD, 4'd15, $urandom, 1'($urandom), !(sent >= 600 && sent < 850));
      end else begin
        n_words = $urandom_range(6, 1);
        for (int k = 0; k < n_words; k++) begin
          case ($urandom_range(5))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2, 3:    value = $urandom;
            default: value = $urandom_range(2000) - 1000;
          endcase
          // break a record now and then
          eor = (k == n_words - 1) ? ($urandom_range(99) >= 5) : ($urandom_range(99) < 5);
          send_word(OP_ADD, LANE_W'($urandom_range(LANES - 1)), value, eor,
                    !(sent >= 600 && sent < 850));
        end
      end
      if (!paused && sent >= 400) begin
        paused = 1'b1;
        drain_updates();
      end
    end

    drain_updates();
    repeat (TAIL_CYC) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS multi_lane_running_average_core");
    end else begin
      $display("FAIL multi_lane_running_average_core");
    end
    $finish;
  end

  initial begin : watchdog
    #(20 * LIMIT_CYC);
    $display("FAIL multi_lane_running_average_core");
    $finish;
  end

endmodule

### sim.f
design/mlra_pkg.sv
design/mlra_front.sv
design/mlra_div.sv
design/mlra_back.sv
design/multi_lane_running_average_core.sv
tb/multi_lane_running_average_core_test.sv
